FILE: hw/rtl/ptt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants of the periodic timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   localparam int TASK_W   = 8;
   localparam int TIME_W   = 48;
   localparam int DELAY_W  = 32;
   localparam int PERIOD_W = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_TICK     = 2'd0,
      OP_SCHEDULE = 2'd1,
      OP_CANCEL   = 2'd2,
      OP_STOP     = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_STOPPED = 2'd2
   } status_type;

   // What the table sweep does to each entry it visits.
   typedef enum logic [1:0] {
      SCAN_KEEP,
      SCAN_TICK,
      SCAN_CANCEL
   } scan_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_MIN,
      ST_FIRE,
      ST_SUMMARY
   } state_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic [TIME_W-1:0]   deadline;
      logic [TASK_W-1:0]   task_id;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage : ptt_pkg
`default_nettype wire

FILE: hw/rtl/ptt_table_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_table_ram
// Single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module ptt_table_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : ptt_table_ram
`default_nettype wire

FILE: hw/rtl/periodic_timer_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_timer_table
// Table of periodic and one-shot timers, kept in scheduling order.
// ----------------------------------------------------------------------------
// Usage. One command beat enters on the req_ channel: tick, schedule, cancel
// or stop. Each command sweeps the timer table once, one entry at a time,
// through a single 48-bit adder and a single magnitude comparator. A tick
// sends one rsp_ beat per fired timer, in table order, and every command
// ends with a summary beat that carries tlast, the status, the earliest
// remaining deadline and the empty flag.
// Each entry of the sweep needs a RAM read, an update and a minimum step,
// in the states READ, EVAL and MIN; a fired timer adds a FIRE state.
// req_tready is high only between commands. Entries that are removed are
// squeezed out during the same sweep by writing kept entries back behind
// the read pointer.
// Reset clears the timer count, the millisecond counter and the stop flag;
// the table RAM is not cleared. When the receiver holds rsp_tready low, the
// sweep waits on the pending beat and nothing is lost.
// ----------------------------------------------------------------------------
module periodic_timer_table
   import ptt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // req_tdata: task_id[7:0], delay[39:8], period[71:40]
   input  wire logic [71:0] req_tdata,
   // req_tuser: operation[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // rsp_tdata: fired_task[7:0], status[9:8], next_deadline[57:10],
   // table_empty[58], zero fill[63:59]
   output logic [63:0]      rsp_tdata,
   // rsp_tuser: fired[0]
   output logic             rsp_tuser,
   output logic             rsp_tlast
);

   state_type state_ff, state_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  wr_ff, wr_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic              stopped_ff, stopped_in;
   scan_type          scan_ff, scan_in;
   status_type        status_ff, status_in;
   logic [TASK_W-1:0] task_id_ff, task_id_in;
   logic [TIME_W-1:0] min_ff, min_in;
   logic              any_ff, any_in;
   logic [TIME_W-1:0] newdl_ff, newdl_in;
   logic              keep_ff, keep_in;
   logic              due_ff, due_in;
   logic [TASK_W-1:0] fire_task_ff, fire_task_in;

   logic [TIME_W-1:0] add_a, add_b, add_sum;
   logic [TIME_W-1:0] cmp_a, cmp_b;
   logic              cmp_lt;

   logic              ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   entry_type         ram_wr_data, ram_rd_data;

   logic              req_fire;
   op_type            req_op;
   logic [TASK_W-1:0]   req_task;
   logic [DELAY_W-1:0]  req_delay;
   logic [PERIOD_W-1:0] req_period;
   logic              due, drop;

   assign req_op     = op_type'(req_tuser);
   assign req_task   = req_tdata[7:0];
   assign req_delay  = req_tdata[39:8];
   assign req_period = req_tdata[71:40];
   assign req_fire   = req_tvalid && req_tready;

   ptt_table_ram #(
      .WIDTH  (ENTRY_W),
      .DEPTH  (ENTRIES),
      .ADDR_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // The one adder (used in IDLE and EVAL) and the one comparator (used in EVAL and MIN).
   assign add_sum = add_a + add_b;
   assign cmp_lt  = cmp_a < cmp_b;

   always_comb begin
      add_a = time_ff;
      add_b = {{(TIME_W-DELAY_W){1'b0}}, req_delay};
      cmp_a = time_ff;
      cmp_b = ram_rd_data.deadline;
      case (state_ff)
         ST_IDLE: begin
            if (req_op == OP_TICK) begin
               add_b = TIME_W'(1);
            end
         end
         ST_EVAL: begin
            add_a = ram_rd_data.deadline;
            add_b = {{(TIME_W-PERIOD_W){1'b0}}, ram_rd_data.period};
         end
         ST_MIN: begin
            cmp_a = newdl_ff;
            cmp_b = min_ff;
         end
         default: begin
         end
      endcase
   end

   // A due timer has deadline <= time, i.e. not (time < deadline).
   assign due  = (scan_ff == SCAN_TICK) && !cmp_lt;
   assign drop = ((scan_ff == SCAN_CANCEL) && (ram_rd_data.task_id == task_id_ff)) ||
                 (due && (ram_rd_data.period == '0));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = (rd_ff == count_ff) ? ST_SUMMARY : ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_MIN;
         end
         ST_MIN: begin
            state_in = due_ff ? ST_FIRE : ST_READ;
         end
         ST_FIRE: begin
            if (rsp_tready) begin
               state_in = ST_READ;
            end
         end
         ST_SUMMARY: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and RAM control.
   always_comb begin
      count_in     = count_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      time_in      = time_ff;
      stopped_in   = stopped_ff;
      scan_in      = scan_ff;
      status_in    = status_ff;
      task_id_in   = task_id_ff;
      min_in       = min_ff;
      any_in       = any_ff;
      newdl_in     = newdl_ff;
      keep_in      = keep_ff;
      due_in       = due_ff;
      fire_task_in = fire_task_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wr_ff[IDX_W-1:0];
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               task_id_in = req_task;
               status_in  = STATUS_DONE;
               scan_in    = SCAN_KEEP;
               any_in     = 1'b0;
               rd_in      = '0;
               wr_in      = '0;
               if (stopped_ff) begin
                  status_in = STATUS_STOPPED;
               end else begin
                  case (req_op)
                     OP_TICK: begin
                        time_in = add_sum;
                        scan_in = SCAN_TICK;
                     end
                     OP_SCHEDULE: begin
                        if (count_ff >= CNT_W'(ENTRIES)) begin
                           status_in = STATUS_FULL;
                        end else begin
                           ram_wr_en            = 1'b1;
                           ram_wr_addr          = count_ff[IDX_W-1:0];
                           ram_wr_data.task_id  = req_task;
                           ram_wr_data.deadline = add_sum;
                           ram_wr_data.period   = req_period;
                           count_in             = count_ff + CNT_W'(1);
                        end
                     end
                     OP_CANCEL: begin
                        scan_in = SCAN_CANCEL;
                     end
                     OP_STOP: begin
                        stopped_in = 1'b1;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_READ: begin
            if (rd_ff == count_ff) begin
               count_in = wr_ff;
            end else begin
               ram_rd_en = 1'b1;
            end
         end
         ST_EVAL: begin
            keep_in      = !drop;
            due_in       = due;
            fire_task_in = ram_rd_data.task_id;
            newdl_in     = due ? add_sum : ram_rd_data.deadline;
            rd_in        = rd_ff + CNT_W'(1);
            if (!drop) begin
               // Kept entries slide down over the removed ones.
               ram_wr_en            = 1'b1;
               ram_wr_data.deadline = newdl_in;
               wr_in                = wr_ff + CNT_W'(1);
            end
         end
         ST_MIN: begin
            if (keep_ff && (!any_ff || cmp_lt)) begin
               min_in = newdl_ff;
               any_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_tuser  = 1'b0;
      rsp_tlast  = 1'b0;
      rsp_tdata  = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_FIRE: begin
            rsp_tvalid      = 1'b1;
            rsp_tuser       = 1'b1;
            rsp_tdata[7:0]  = fire_task_ff;
         end
         ST_SUMMARY: begin
            rsp_tvalid       = 1'b1;
            rsp_tlast        = 1'b1;
            rsp_tdata[9:8]   = status_ff;
            rsp_tdata[57:10] = any_ff ? min_ff : '0;
            rsp_tdata[58]    = (count_ff == '0);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         time_ff    <= '0;
         stopped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         time_ff    <= time_in;
         stopped_ff <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff        <= rd_in;
      wr_ff        <= wr_in;
      scan_ff      <= scan_in;
      status_ff    <= status_in;
      task_id_ff   <= task_id_in;
      min_ff       <= min_in;
      any_ff       <= any_in;
      newdl_ff     <= newdl_in;
      keep_ff      <= keep_in;
      due_ff       <= due_in;
      fire_task_ff <= fire_task_in;
   end

   // The block never takes a command while a response beat is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("command accepted while a response is pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("timer count exceeds table size");

   // Only firing beats may come without tlast.
   a_fire_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser)
      else $error("non-final beat that is not a firing");

   a_stop_sticks: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("stopped block restarted");

endmodule : periodic_timer_table
`default_nettype wire
